@@ src/argt_pkg.sv @@
// Package: widths, register indexes, reset values and sequencer states of the range gauge tracker.
package argt_pkg;

  localparam int unsigned PRICE_W    = 48;
  localparam int unsigned FACT_W     = 32;
  localparam int unsigned WIN_W      = 11;
  localparam int unsigned RET_W      = 32;
  localparam int unsigned GAUGE_W    = 15;
  localparam int unsigned VOL_W      = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIV_LO_W   = 32;
  localparam int unsigned DIV_CNT_W  = 6;

  localparam int unsigned MAX_WINDOW_DEF = 1024;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_INIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_INIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_SMOOTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_SMOOTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN   = 3'd4;

  localparam logic [FACT_W-1:0] LOWER_INIT_RST   = 32'd1073204953;
  localparam logic [FACT_W-1:0] UPPER_INIT_RST   = 32'd1074278695;
  localparam logic [FACT_W-1:0] LOWER_SMOOTH_RST = 32'd1073752561;
  localparam logic [FACT_W-1:0] UPPER_SMOOTH_RST = 32'd1073731087;
  localparam logic [WIN_W-1:0]  WINDOW_LEN_RST   = 11'd800;

  localparam logic [PRICE_W-1:0] PMASK      = {PRICE_W{1'b1}};
  localparam logic [RET_W-1:0]   RET_MAX    = 32'hFF00_0000;
  localparam logic [GAUGE_W-1:0] GAUGE_MID  = 15'd12800;
  localparam logic [GAUGE_W-1:0] GAUGE_FULL = 15'd25600;

  localparam logic [DIV_CNT_W-1:0] RET_STEPS   = 6'd32;
  localparam logic [DIV_CNT_W-1:0] VOL_STEPS   = 6'd31;
  localparam logic [DIV_CNT_W-1:0] GAUGE_STEPS = 6'd15;

  typedef enum logic [18:0] {
    ST_IDLE    = 19'd1 << 0,
    ST_RET     = 19'd1 << 1,
    ST_RDIV    = 19'd1 << 2,
    ST_RWR     = 19'd1 << 3,
    ST_NCALC   = 19'd1 << 4,
    ST_ADJ     = 19'd1 << 5,
    ST_ADJ_ACC = 19'd1 << 6,
    ST_VOL     = 19'd1 << 7,
    ST_VDIV    = 19'd1 << 8,
    ST_MSET    = 19'd1 << 9,
    ST_MA      = 19'd1 << 10,
    ST_MB      = 19'd1 << 11,
    ST_MC      = 19'd1 << 12,
    ST_SNAP    = 19'd1 << 13,
    ST_FIX     = 19'd1 << 14,
    ST_GCHK    = 19'd1 << 15,
    ST_GLOAD   = 19'd1 << 16,
    ST_GDIV    = 19'd1 << 17,
    ST_OUT     = 19'd1 << 18
  } state_e;

endpackage

@@ src/adaptive_range_gauge_tracker.sv @@
// Top level: range gauge tracker with shared multiplier, shared divider and return ring.
//
// Input channel: in_valid_i / in_stall_o with price_i (unsigned, 24 fraction bits).
// A request is taken when in_valid_i is high and in_stall_o is low. in_stall_o is
// low only while the sequencer is idle, so one request is in work at a time.
// Output channel: out_valid_o / out_stall_i with gauge position, volatility and
// the two bounds. The result sits in an output register; the next request is
// taken while it waits, and that request's result waits in the sequencer until
// the output register is taken.
// A request runs through the return divider, the ring write, one add or drop on
// the running sum per ring entry changed (one per request in steady state, up to
// the window length after a window_length change), the volatility divider, the
// two bounds on the 24x32 multiplier and the gauge divider, in that order.
// A saturated return or a clamped gauge skips its divider.
// Configuration writes take effect at once; the user makes them while idle, as the block does not enforce it.
// Reset clears bounds, counters and the running sum; the ring needs no clear.
module adaptive_range_gauge_tracker #(
  parameter int unsigned MAX_WINDOW = argt_pkg::MAX_WINDOW_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [argt_pkg::PRICE_W-1:0]     price_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [argt_pkg::GAUGE_W-1:0]     gauge_position_o,
  output logic [argt_pkg::VOL_W-1:0]       volatility_percent_o,
  output logic [argt_pkg::PRICE_W-1:0]     lower_bound_o,
  output logic [argt_pkg::PRICE_W-1:0]     upper_bound_o,
  input  logic                             cfg_we_i,
  input  logic [argt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [argt_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned PW    = argt_pkg::PRICE_W;
  localparam int unsigned AW    = $clog2(MAX_WINDOW);
  localparam int unsigned SW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned WW    = (SW > argt_pkg::WIN_W) ? SW : argt_pkg::WIN_W;
  localparam int unsigned SUM_W = argt_pkg::RET_W + AW;
  localparam int unsigned XW    = SUM_W + 7;

  argt_pkg::state_e state_q, state_d;

  logic [argt_pkg::FACT_W-1:0] lif_q, uif_q, ls_q, us_q;
  logic [argt_pkg::WIN_W-1:0]  win_len_q;

  logic [PW-1:0]    price_q, price_d;
  logic [PW-1:0]    prior_q, prior_d;
  logic [PW-1:0]    low_q, low_d, high_q, high_d;
  logic             bvalid_q, bvalid_d;
  logic             first_q, first_d;
  logic [SW-1:0]    seen_q, seen_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic [AW-1:0]    n_q, n_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             adj_sub_q, adj_sub_d;
  logic             sel_q, sel_d;

  logic [argt_pkg::RET_W-1:0]   ret_q, ret_d;
  logic [argt_pkg::VOL_W-1:0]   vol_q, vol_d;
  logic [argt_pkg::GAUGE_W-1:0] gauge_q, gauge_d;
  logic [PW-1:0]                a_q, a_d;
  logic [argt_pkg::FACT_W-1:0]  f_q, f_d;
  logic [55:0]                  tmp_q, tmp_d;
  logic [PW-1:0]                m_q, m_d;

  logic [PW-1:0]                   div_r_q, div_r_d, div_den_q, div_den_d;
  logic [argt_pkg::DIV_LO_W-1:0]   div_lo_q, div_lo_d, div_qt_q, div_qt_d;
  logic [argt_pkg::DIV_CNT_W-1:0]  div_cnt_q, div_cnt_d;

  logic                          out_valid_q, out_valid_d;
  logic [argt_pkg::GAUGE_W-1:0]  out_gauge_q;
  logic [argt_pkg::VOL_W-1:0]    out_vol_q;
  logic [PW-1:0]                 out_low_q, out_high_q;

  logic [argt_pkg::RET_W-1:0] ring_q [MAX_WINDOW];
  logic [argt_pkg::RET_W-1:0] rd_q;
  logic [AW-1:0]              rd_addr;

  // shared divider step
  logic [PW:0]                   div_t, div_sub;
  logic                          div_ge;
  logic [PW-1:0]                 div_r_nx;
  logic [argt_pkg::DIV_LO_W-1:0] div_qt_nx;
  logic                          div_last;

  // shared multiplier
  logic [23:0] mul_a;
  logic [55:0] prod;
  logic [56:0] comb;
  logic [PW-1:0] m_nx;

  logic [XW-1:0] x_full;
  logic [62:0]   gnum;
  logic [PW:0]   mid_sum;
  logic [PW-1:0] mid;
  logic [PW:0]   up_sum;
  logic [PW-1:0] old_b;
  logic [55:0]   sat_lim;
  logic [WW-1:0] win_min;
  logic          take;

  function automatic logic [AW-1:0] sub_mod(input logic [AW-1:0] p, input logic [AW:0] k);
    logic [AW:0] s;
    s = {1'b0, p} + (AW+1)'(MAX_WINDOW) - k;
    if (s >= (AW+1)'(MAX_WINDOW)) s = s - (AW+1)'(MAX_WINDOW);
    return s[AW-1:0];
  endfunction

  assign in_stall_o = (state_q != argt_pkg::ST_IDLE);
  assign take       = in_valid_i && !in_stall_o;

  assign div_t     = {div_r_q, div_lo_q[argt_pkg::DIV_LO_W-1]};
  assign div_sub   = div_t - {1'b0, div_den_q};
  assign div_ge    = (div_t >= {1'b0, div_den_q});
  assign div_r_nx  = div_ge ? div_sub[PW-1:0] : div_t[PW-1:0];
  assign div_qt_nx = {div_qt_q[argt_pkg::DIV_LO_W-2:0], div_ge};
  assign div_last  = (div_cnt_q == argt_pkg::DIV_CNT_W'(1));

  assign mul_a = (state_q == argt_pkg::ST_MA) ? a_q[23:0] : a_q[47:24];
  assign prod  = 56'(mul_a) * 56'(f_q);
  assign comb  = {1'b0, prod} + 57'(tmp_q >> 24);
  assign m_nx  = (|comb[56:54]) ? argt_pkg::PMASK : comb[53:6];

  assign x_full  = (XW'(sum_q) << 6) + (XW'(sum_q) << 5) + (XW'(sum_q) << 2);
  assign gnum    = (63'(a_q) << 14) + (63'(a_q) << 13) + (63'(a_q) << 10);
  assign mid_sum = {1'b0, low_q} + {1'b0, high_q};
  assign mid     = mid_sum[PW:1];
  assign up_sum  = {1'b0, price_q} + {1'b0, m_q};
  assign old_b   = sel_q ? high_q : low_q;
  assign sat_lim = {prior_q, 8'd0} - {8'd0, prior_q};

  always_comb begin
    logic [WW-1:0] wa, ws;
    wa = WW'(win_len_q);
    ws = WW'(seen_q);
    win_min = WW'(MAX_WINDOW);
    if (wa < win_min) win_min = wa;
    if (ws < win_min) win_min = ws;
  end

  assign rd_addr = adj_sub_d ? sub_mod(ptr_q, cnt_q) : sub_mod(ptr_q, cnt_q + 1'b1);

  always_comb begin
    state_d     = state_q;
    price_d     = price_q;
    prior_d     = prior_q;
    low_d       = low_q;
    high_d      = high_q;
    bvalid_d    = bvalid_q;
    first_d     = first_q;
    seen_d      = seen_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    sum_d       = sum_q;
    adj_sub_d   = (cnt_q > {1'b0, n_q});
    sel_d       = sel_q;
    ret_d       = ret_q;
    vol_d       = vol_q;
    gauge_d     = gauge_q;
    a_d         = a_q;
    f_d         = f_q;
    tmp_d       = tmp_q;
    m_d         = m_q;
    div_r_d     = div_r_q;
    div_den_d   = div_den_q;
    div_lo_d    = div_lo_q;
    div_qt_d    = div_qt_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      argt_pkg::ST_IDLE: begin
        if (take) begin
          price_d  = price_i;
          a_d      = (price_i >= prior_q) ? price_i - prior_q : prior_q - price_i;
          first_d  = !bvalid_q;
          bvalid_d = 1'b1;
          if (seen_q < SW'(MAX_WINDOW)) seen_d = seen_q + 1'b1;
          state_d  = (seen_q != '0) ? argt_pkg::ST_RET : argt_pkg::ST_NCALC;
        end
      end
      argt_pkg::ST_RET: begin
        if (prior_q == '0) begin
          ret_d   = '0;
          state_d = argt_pkg::ST_RWR;
        end else if ({8'd0, a_q} >= sat_lim) begin
          ret_d   = argt_pkg::RET_MAX;
          state_d = argt_pkg::ST_RWR;
        end else begin
          div_r_d   = PW'(a_q >> 8);
          div_den_d = prior_q;
          div_lo_d  = {a_q[7:0], 24'd0};
          div_qt_d  = '0;
          div_cnt_d = argt_pkg::RET_STEPS;
          state_d   = argt_pkg::ST_RDIV;
        end
      end
      argt_pkg::ST_RDIV: begin
        div_r_d   = div_r_nx;
        div_qt_d  = div_qt_nx;
        div_lo_d  = div_lo_q << 1;
        div_cnt_d = div_cnt_q - 1'b1;
        if (div_last) begin
          ret_d   = div_qt_nx;
          state_d = argt_pkg::ST_RWR;
        end
      end
      argt_pkg::ST_RWR: begin
        ptr_d   = (ptr_q == AW'(MAX_WINDOW - 1)) ? '0 : ptr_q + 1'b1;
        sum_d   = sum_q + SUM_W'(ret_q);
        cnt_d   = cnt_q + 1'b1;
        state_d = argt_pkg::ST_NCALC;
      end
      argt_pkg::ST_NCALC: begin
        prior_d = price_q;
        n_d     = (win_min >= WW'(2)) ? AW'(win_min - WW'(1)) : '0;
        state_d = argt_pkg::ST_ADJ;
      end
      argt_pkg::ST_ADJ: begin
        if (cnt_q == {1'b0, n_q}) state_d = argt_pkg::ST_VOL;
        else                      state_d = argt_pkg::ST_ADJ_ACC;
      end
      argt_pkg::ST_ADJ_ACC: begin
        adj_sub_d = adj_sub_q;
        if (adj_sub_q) begin
          sum_d = sum_q - SUM_W'(rd_q);
          cnt_d = cnt_q - 1'b1;
        end else begin
          sum_d = sum_q + SUM_W'(rd_q);
          cnt_d = cnt_q + 1'b1;
        end
        state_d = argt_pkg::ST_ADJ;
      end
      argt_pkg::ST_VOL: begin
        sel_d = 1'b0;
        if (n_q == '0) begin
          vol_d   = '0;
          state_d = argt_pkg::ST_MSET;
        end else begin
          div_r_d   = PW'(x_full >> 39);
          div_den_d = PW'(n_q);
          div_lo_d  = {x_full[38:8], 1'b0};
          div_qt_d  = '0;
          div_cnt_d = argt_pkg::VOL_STEPS;
          state_d   = argt_pkg::ST_VDIV;
        end
      end
      argt_pkg::ST_VDIV: begin
        div_r_d   = div_r_nx;
        div_qt_d  = div_qt_nx;
        div_lo_d  = div_lo_q << 1;
        div_cnt_d = div_cnt_q - 1'b1;
        if (div_last) begin
          vol_d   = div_qt_nx[argt_pkg::VOL_W-1:0];
          state_d = argt_pkg::ST_MSET;
        end
      end
      argt_pkg::ST_MSET: begin
        if (first_q) begin
          a_d = price_q;
          f_d = sel_q ? uif_q : lif_q;
        end else begin
          a_d = (old_b >= price_q) ? old_b - price_q : price_q - old_b;
          f_d = sel_q ? us_q : ls_q;
        end
        state_d = argt_pkg::ST_MA;
      end
      argt_pkg::ST_MA: begin
        tmp_d   = prod;
        state_d = argt_pkg::ST_MB;
      end
      argt_pkg::ST_MB: begin
        m_d     = m_nx;
        state_d = argt_pkg::ST_MC;
      end
      argt_pkg::ST_MC: begin
        logic [PW-1:0] res;
        if (first_q)               res = m_q;
        else if (old_b >= price_q) res = up_sum[PW] ? argt_pkg::PMASK : up_sum[PW-1:0];
        else                       res = (m_q > price_q) ? '0 : price_q - m_q;
        if (sel_q) high_d = res;
        else       low_d  = res;
        if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = argt_pkg::ST_MSET;
        end else begin
          state_d = first_q ? argt_pkg::ST_GCHK : argt_pkg::ST_SNAP;
        end
      end
      argt_pkg::ST_SNAP: begin
        if (price_q < low_q)  low_d  = price_q;
        if (price_q > high_q) high_d = price_q;
        state_d = argt_pkg::ST_FIX;
      end
      argt_pkg::ST_FIX: begin
        if (high_q <= low_q) begin
          low_d  = (mid != '0) ? mid - 1'b1 : '0;
          high_d = (mid != argt_pkg::PMASK) ? mid + 1'b1 : argt_pkg::PMASK;
        end
        state_d = argt_pkg::ST_GCHK;
      end
      argt_pkg::ST_GCHK: begin
        if (high_q <= low_q) begin
          gauge_d = argt_pkg::GAUGE_MID;
          state_d = argt_pkg::ST_OUT;
        end else if (price_q <= low_q) begin
          gauge_d = '0;
          state_d = argt_pkg::ST_OUT;
        end else if (price_q >= high_q) begin
          gauge_d = argt_pkg::GAUGE_FULL;
          state_d = argt_pkg::ST_OUT;
        end else begin
          a_d       = price_q - low_q;
          div_den_d = high_q - low_q;
          state_d   = argt_pkg::ST_GLOAD;
        end
      end
      argt_pkg::ST_GLOAD: begin
        div_r_d   = PW'(gnum >> 15);
        div_lo_d  = {gnum[14:0], 17'd0};
        div_qt_d  = '0;
        div_cnt_d = argt_pkg::GAUGE_STEPS;
        state_d   = argt_pkg::ST_GDIV;
      end
      argt_pkg::ST_GDIV: begin
        div_r_d   = div_r_nx;
        div_qt_d  = div_qt_nx;
        div_lo_d  = div_lo_q << 1;
        div_cnt_d = div_cnt_q - 1'b1;
        if (div_last) begin
          gauge_d = div_qt_nx[argt_pkg::GAUGE_W-1:0];
          state_d = argt_pkg::ST_OUT;
        end
      end
      argt_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          state_d     = argt_pkg::ST_IDLE;
        end
      end
      default: state_d = argt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= argt_pkg::ST_IDLE;
      lif_q       <= argt_pkg::LOWER_INIT_RST;
      uif_q       <= argt_pkg::UPPER_INIT_RST;
      ls_q        <= argt_pkg::LOWER_SMOOTH_RST;
      us_q        <= argt_pkg::UPPER_SMOOTH_RST;
      win_len_q   <= argt_pkg::WINDOW_LEN_RST;
      prior_q     <= '0;
      low_q       <= '0;
      high_q      <= '0;
      bvalid_q    <= 1'b0;
      seen_q      <= '0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prior_q     <= prior_d;
      low_q       <= low_d;
      high_q      <= high_d;
      bvalid_q    <= bvalid_d;
      seen_q      <= seen_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          argt_pkg::CFG_LOWER_INIT:   lif_q     <= cfg_data_i;
          argt_pkg::CFG_UPPER_INIT:   uif_q     <= cfg_data_i;
          argt_pkg::CFG_LOWER_SMOOTH: ls_q      <= cfg_data_i;
          argt_pkg::CFG_UPPER_SMOOTH: us_q      <= cfg_data_i;
          argt_pkg::CFG_WINDOW_LEN:   win_len_q <= cfg_data_i[argt_pkg::WIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    price_q   <= price_d;
    first_q   <= first_d;
    n_q       <= n_d;
    adj_sub_q <= adj_sub_d;
    sel_q     <= sel_d;
    ret_q     <= ret_d;
    vol_q     <= vol_d;
    gauge_q   <= gauge_d;
    a_q       <= a_d;
    f_q       <= f_d;
    tmp_q     <= tmp_d;
    m_q       <= m_d;
    div_r_q   <= div_r_d;
    div_den_q <= div_den_d;
    div_lo_q  <= div_lo_d;
    div_qt_q  <= div_qt_d;
    div_cnt_q <= div_cnt_d;
    if (state_q == argt_pkg::ST_OUT && (!out_valid_q || !out_stall_i)) begin
      out_gauge_q <= gauge_q;
      out_vol_q   <= vol_q;
      out_low_q   <= low_q;
      out_high_q  <= high_q;
    end
  end

  // return ring
  always_ff @(posedge clk_i) begin
    if (state_q == argt_pkg::ST_RWR) ring_q[ptr_q] <= ret_q;
    if (state_q == argt_pkg::ST_ADJ) rd_q <= ring_q[rd_addr];
  end

  assign out_valid_o          = out_valid_q;
  assign gauge_position_o     = out_gauge_q;
  assign volatility_percent_o = out_vol_q;
  assign lower_bound_o        = out_low_q;
  assign upper_bound_o        = out_high_q;

  a_div_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == argt_pkg::ST_RDIV || state_q == argt_pkg::ST_VDIV ||
     state_q == argt_pkg::ST_GDIV) |-> div_r_q < div_den_q)
    else $error("divider remainder not below divisor");

  a_sum_count_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == argt_pkg::ST_VOL) |-> cnt_q == {1'b0, n_q})
    else $error("running sum count differs from window");

  a_range_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == argt_pkg::ST_GCHK && !first_q) |-> high_q > low_q)
    else $error("empty range after widening");

  a_take_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (state_q == argt_pkg::ST_RET || state_q == argt_pkg::ST_NCALC))
    else $error("accepted request did not start");

endmodule
